@@ rtl/core/adpcm_vd_pkg.sv @@
// Package for the multichannel IMA ADPCM voice decoder.
// Holds the request/result structs, command codes and the step/index tables.
// No dependencies.
package adpcm_vd_pkg;

  // Default voice count and table limits
  localparam int unsigned VOICES_DEF = 16;
  localparam int unsigned IDX_MAX    = 88;

  // Command codes
  localparam logic [1:0] CMD_DECODE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_LOOP   = 2'd2;

  // Input request
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  voice;
    logic [7:0]  data_byte;
    logic [31:0] reload_word;
  } adpcm_in_t;

  // Result
  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         voice_out;
    logic               advance_byte;
    logic [6:0]         step_index;
  } adpcm_out_t;

  // IMA step size for an index in 0..88
  function automatic logic [15:0] step_of(input logic [6:0] idx);
    logic [15:0] s;
    case (idx)
      7'd0:  s = 16'h0007;  7'd1:  s = 16'h0008;  7'd2:  s = 16'h0009;
      7'd3:  s = 16'h000A;  7'd4:  s = 16'h000B;  7'd5:  s = 16'h000C;
      7'd6:  s = 16'h000D;  7'd7:  s = 16'h000E;  7'd8:  s = 16'h0010;
      7'd9:  s = 16'h0011;  7'd10: s = 16'h0013;  7'd11: s = 16'h0015;
      7'd12: s = 16'h0017;  7'd13: s = 16'h0019;  7'd14: s = 16'h001C;
      7'd15: s = 16'h001F;  7'd16: s = 16'h0022;  7'd17: s = 16'h0025;
      7'd18: s = 16'h0029;  7'd19: s = 16'h002D;  7'd20: s = 16'h0032;
      7'd21: s = 16'h0037;  7'd22: s = 16'h003C;  7'd23: s = 16'h0042;
      7'd24: s = 16'h0049;  7'd25: s = 16'h0050;  7'd26: s = 16'h0058;
      7'd27: s = 16'h0061;  7'd28: s = 16'h006B;  7'd29: s = 16'h0076;
      7'd30: s = 16'h0082;  7'd31: s = 16'h008F;  7'd32: s = 16'h009D;
      7'd33: s = 16'h00AD;  7'd34: s = 16'h00BE;  7'd35: s = 16'h00D1;
      7'd36: s = 16'h00E6;  7'd37: s = 16'h00FD;  7'd38: s = 16'h0117;
      7'd39: s = 16'h0133;  7'd40: s = 16'h0151;  7'd41: s = 16'h0173;
      7'd42: s = 16'h0198;  7'd43: s = 16'h01C1;  7'd44: s = 16'h01EE;
      7'd45: s = 16'h0220;  7'd46: s = 16'h0256;  7'd47: s = 16'h0292;
      7'd48: s = 16'h02D4;  7'd49: s = 16'h031C;  7'd50: s = 16'h036C;
      7'd51: s = 16'h03C3;  7'd52: s = 16'h0424;  7'd53: s = 16'h048E;
      7'd54: s = 16'h0502;  7'd55: s = 16'h0583;  7'd56: s = 16'h0610;
      7'd57: s = 16'h06AB;  7'd58: s = 16'h0756;  7'd59: s = 16'h0812;
      7'd60: s = 16'h08E0;  7'd61: s = 16'h09C3;  7'd62: s = 16'h0ABD;
      7'd63: s = 16'h0BD0;  7'd64: s = 16'h0CFF;  7'd65: s = 16'h0E4C;
      7'd66: s = 16'h0FBA;  7'd67: s = 16'h114C;  7'd68: s = 16'h1307;
      7'd69: s = 16'h14EE;  7'd70: s = 16'h1706;  7'd71: s = 16'h1954;
      7'd72: s = 16'h1BDC;  7'd73: s = 16'h1EA5;  7'd74: s = 16'h21B6;
      7'd75: s = 16'h2515;  7'd76: s = 16'h28CA;  7'd77: s = 16'h2CDF;
      7'd78: s = 16'h315B;  7'd79: s = 16'h364B;  7'd80: s = 16'h3BB9;
      7'd81: s = 16'h41B2;  7'd82: s = 16'h4844;  7'd83: s = 16'h4F7E;
      7'd84: s = 16'h5771;  7'd85: s = 16'h602F;  7'd86: s = 16'h69CE;
      7'd87: s = 16'h7462;
      default: s = 16'h7FFF;
    endcase
    return s;
  endfunction

  // Index adjustment for the nibble magnitude
  function automatic logic signed [4:0] idx_move(input logic [2:0] mag);
    logic signed [4:0] m;
    case (mag)
      3'd4:    m = 5'sd2;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd6;
      3'd7:    m = 5'sd8;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/multichannel_adpcm_voice_decoder.sv @@
// Multichannel IMA ADPCM voice decoder, top level.
// Uses adpcm_vd_pkg for the request/result structs, command codes and tables.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------
//   in_     | request   | in_valid / in_stall | adpcm_in_t  (cmd, voice, ...)
//   out_    | result    | out_valid/out_stall | adpcm_out_t (sample, ...)
//
// Every request gives one result. The request is held in the input register
// while the decode logic works on it, and the result register loads from it
// when the request fires; out_valid rises as the result register loads.
// A new request is taken every cycle while the result side keeps up; a stall
// on out_ holds the result register and then the input register.
// Reset clears all voice state (predictor, index, toggle) at once.
module multichannel_adpcm_voice_decoder #(
  parameter int unsigned VOICES = adpcm_vd_pkg::VOICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  adpcm_vd_pkg::adpcm_in_t  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output adpcm_vd_pkg::adpcm_out_t out_data
);
  import adpcm_vd_pkg::*;

  localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Pipeline registers
  adpcm_in_t  req_r;
  logic       req_valid_r;
  adpcm_out_t res_r, res_nxt;
  logic       res_valid_r;

  // Per-voice state
  logic [15:0] pred_r [VOICES];
  logic [6:0]  sidx_r [VOICES];
  logic        tog_r  [VOICES];

  logic              fire;
  logic [5:0]        voice_wide;
  logic              in_range;
  logic [VIDX_W-1:0] vidx;
  logic [15:0]       cur_pred;
  logic [6:0]        cur_sidx;
  logic              cur_tog;
  logic [6:0]        si;
  logic [15:0]       step;
  logic [3:0]        nib;
  logic [16:0]       diff;
  logic signed [17:0] p_ext, d_ext, p_sum;
  logic [15:0]       dec_pred;
  logic signed [7:0] ni;
  logic [6:0]        dec_sidx;
  logic [6:0]        ld_sidx;
  logic [15:0]       pred_nxt;
  logic [6:0]        sidx_nxt;
  logic              tog_nxt;
  logic              adv;

  // Handshake: move the request forward when the result register frees up
  assign fire      = req_valid_r && (!res_valid_r || !out_stall);
  assign in_stall  = req_valid_r && !fire;
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // Voice selection
  assign voice_wide = {2'b00, req_r.voice};
  assign in_range   = (voice_wide < 6'(VOICES));
  assign vidx       = voice_wide[VIDX_W-1:0];
  assign cur_pred   = pred_r[vidx];
  assign cur_sidx   = sidx_r[vidx];
  assign cur_tog    = tog_r[vidx];

  // Decode one nibble: step difference, saturated add, index update
  always_comb begin
    si   = (cur_sidx > 7'(IDX_MAX)) ? 7'(IDX_MAX) : cur_sidx;
    step = step_of(si);
    nib  = cur_tog ? req_r.data_byte[7:4] : req_r.data_byte[3:0];
    diff = {1'b0, step >> 3};
    if (nib[0]) diff = diff + {1'b0, step >> 2};
    if (nib[1]) diff = diff + {1'b0, step >> 1};
    if (nib[2]) diff = diff + {1'b0, step};
    p_ext = 18'(signed'(cur_pred));
    d_ext = signed'({1'b0, diff});
    p_sum = nib[3] ? (p_ext - d_ext) : (p_ext + d_ext);
    if (p_sum > 18'sd32767) begin
      dec_pred = 16'h7FFF;
    end else if (p_sum < -18'sd32768) begin
      dec_pred = 16'h8000;
    end else begin
      dec_pred = p_sum[15:0];
    end
    ni = signed'({1'b0, si}) + 8'(idx_move(nib[2:0]));
    if (ni < 8'sd0) begin
      dec_sidx = 7'd0;
    end else if (ni > 8'(IDX_MAX)) begin
      dec_sidx = 7'(IDX_MAX);
    end else begin
      dec_sidx = ni[6:0];
    end
  end

  // Reload index, clamped to the table top
  assign ld_sidx = (req_r.reload_word[23:16] > 8'(IDX_MAX)) ? 7'(IDX_MAX)
                                                            : req_r.reload_word[22:16];

  // Select the new voice state per command
  always_comb begin
    pred_nxt = cur_pred;
    sidx_nxt = cur_sidx;
    tog_nxt  = cur_tog;
    adv      = 1'b0;
    case (req_r.cmd)
      CMD_DECODE: begin
        pred_nxt = dec_pred;
        sidx_nxt = dec_sidx;
        tog_nxt  = ~cur_tog;
        adv      = cur_tog;
      end
      CMD_START: begin
        pred_nxt = req_r.reload_word[15:0];
        sidx_nxt = ld_sidx;
        tog_nxt  = 1'b0;
      end
      CMD_LOOP: begin
        if (req_r.reload_word[31]) begin
          pred_nxt = req_r.reload_word[15:0];
          sidx_nxt = ld_sidx;
          tog_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Build the result; voices past the end report zero sample, advance and index
  always_comb begin
    res_nxt.voice_out = req_r.voice;
    if (in_range) begin
      res_nxt.sample       = signed'(pred_nxt);
      res_nxt.advance_byte = adv;
      res_nxt.step_index   = sidx_nxt;
    end else begin
      res_nxt.sample       = '0;
      res_nxt.advance_byte = 1'b0;
      res_nxt.step_index   = '0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid_r <= 1'b1;
    end else if (fire) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
  end

  // Result register: load on fire, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (fire) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  // Voice state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        pred_r[i] <= '0;
        sidx_r[i] <= '0;
        tog_r[i]  <= 1'b0;
      end
    end else if (fire && in_range) begin
      pred_r[vidx] <= pred_nxt;
      sidx_r[vidx] <= sidx_nxt;
      tog_r[vidx]  <= tog_nxt;
    end
  end

endmodule

@@ tb/multichannel_adpcm_voice_decoder_tb.sv @@
// Self-checking testbench for the multichannel IMA ADPCM voice decoder.
// Runs a directed request table, then random requests checked against a predictor.
// Depends on adpcm_vd_pkg and multichannel_adpcm_voice_decoder.
module multichannel_adpcm_voice_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adpcm_vd_pkg::*;

  localparam int NUM_VOICES = 16;
  localparam int IDX_TOP = 88;
  localparam int RANDOM_REQUESTS = 700;
  localparam int PHASES = 4;
  localparam int DRAIN_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int DIR_ROWS = 26;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Idle and stall percentages per handshake phase
  localparam int PHASE_IDLE [PHASES] = '{0, 51, 0, 32};
  localparam int PHASE_STALL [PHASES] = '{0, 0, 51, 32};

  // IMA step sizes and index moves, kept apart from the design's tables
  localparam int STEP_SIZE [0:88] = '{
    7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
    50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230,
    253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876, 963,
    1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272, 2499, 2749, 3024, 3327,
    3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132, 7845, 8630, 9493, 10442,
    11487, 12635, 13899, 15289, 16818, 18500, 20350, 22385, 24623, 27086, 29794,
    32767};
  localparam int IDX_MOVE [0:7] = '{-1, -1, -1, -1, 2, 4, 6, 8};

  typedef struct packed {
    adpcm_in_t  req;
    logic       known;
    adpcm_out_t want;
  } dir_row_t;

  // Directed requests; a typed result is given where it follows at a glance
  localparam dir_row_t SCRIPT [DIR_ROWS] = '{
    '{'{CMD_DECODE, 4'd0,  8'h00, 32'h0000_0000}, 1'b1, '{16'h0000, 4'd0,  1'b0, 7'd0}},
    '{'{CMD_DECODE, 4'd0,  8'h00, 32'h0000_0000}, 1'b1, '{16'h0000, 4'd0,  1'b1, 7'd0}},
    '{'{CMD_START,  4'd1,  8'h00, 32'h0058_7FFF}, 1'b1, '{16'h7FFF, 4'd1,  1'b0, 7'd88}},
    '{'{CMD_DECODE, 4'd1,  8'h07, 32'h0000_0000}, 1'b1, '{16'h7FFF, 4'd1,  1'b0, 7'd88}},
    '{'{CMD_DECODE, 4'd1,  8'h70, 32'h0000_0000}, 1'b1, '{16'h7FFF, 4'd1,  1'b1, 7'd88}},
    '{'{CMD_START,  4'd2,  8'h00, 32'h00FF_8000}, 1'b1, '{16'h8000, 4'd2,  1'b0, 7'd88}},
    '{'{CMD_DECODE, 4'd2,  8'h0F, 32'h0000_0000}, 1'b1, '{16'h8000, 4'd2,  1'b0, 7'd88}},
    '{'{CMD_DECODE, 4'd2,  8'hF0, 32'h0000_0000}, 1'b1, '{16'h8000, 4'd2,  1'b1, 7'd88}},
    '{'{CMD_LOOP,   4'd3,  8'h00, 32'h7FFF_FFFF}, 1'b1, '{16'h0000, 4'd3,  1'b0, 7'd0}},
    '{'{CMD_LOOP,   4'd3,  8'h00, 32'h8023_1234}, 1'b1, '{16'h1234, 4'd3,  1'b0, 7'd35}},
    '{'{CMD_LOOP,   4'd15, 8'h00, 32'hFFFF_FFFF}, 1'b1, '{16'hFFFF, 4'd15, 1'b0, 7'd88}},
    '{'{CMD_UNUSED, 4'd15, 8'hFF, 32'h0000_0000}, 1'b1, '{16'hFFFF, 4'd15, 1'b0, 7'd88}},
    '{'{CMD_START,  4'd4,  8'h00, 32'h0059_0000}, 1'b1, '{16'h0000, 4'd4,  1'b0, 7'd88}},
    '{'{CMD_START,  4'd4,  8'h00, 32'h0000_0000}, 1'b1, '{16'h0000, 4'd4,  1'b0, 7'd0}},
    '{'{CMD_START,  4'd5,  8'h00, 32'h0020_0100}, 1'b1, '{16'h0100, 4'd5,  1'b0, 7'd32}},
    '{'{CMD_DECODE, 4'd5,  8'h98, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd5,  8'h98, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd5,  8'hBA, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd5,  8'hBA, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd5,  8'hDC, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd5,  8'hDC, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd5,  8'h10, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd5,  8'h76, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_DECODE, 4'd6,  8'h5A, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_START,  4'd6,  8'h00, 32'h0010_F000}, 1'b1, '{16'hF000, 4'd6,  1'b0, 7'd16}},
    '{'{CMD_DECODE, 4'd6,  8'h5A, 32'h0000_0000}, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  adpcm_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  adpcm_out_t out_data;

  // Side info that travels with the request being offered
  logic       row_known = 1'b0;
  adpcm_out_t row_want = '0;

  // Predicted per-voice state
  logic [15:0] voice_pred [NUM_VOICES];
  logic [6:0]  voice_idx [NUM_VOICES];
  logic        voice_tog [NUM_VOICES];

  adpcm_out_t pending_results [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int checked_count = 0;
  int decode_count = 0;
  int reload_count = 0;
  bit hung = 1'b0;

  multichannel_adpcm_voice_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the voice state and return the result it yields
  function automatic adpcm_out_t decode_voice_step(adpcm_in_t req);
    adpcm_out_t res;
    int v;
    int si;
    int step;
    int diff;
    int acc;
    int ni;
    logic [3:0] nib;
    logic [7:0] new_idx;
    logic adv;
    v = req.voice;
    adv = 1'b0;
    new_idx = req.reload_word[23:16];
    case (req.cmd)
      CMD_DECODE: begin
        nib = voice_tog[v] ? req.data_byte[7:4] : req.data_byte[3:0];
        si = (voice_idx[v] > IDX_TOP) ? IDX_TOP : voice_idx[v];
        step = STEP_SIZE[si];
        diff = step >> 3;
        if (nib[0]) diff += step >> 2;
        if (nib[1]) diff += step >> 1;
        if (nib[2]) diff += step;
        acc = int'($signed(voice_pred[v]));
        if (nib[3]) begin
          acc -= diff;
          if (acc < -32768) acc = -32768;
        end else begin
          acc += diff;
          if (acc > 32767) acc = 32767;
        end
        voice_pred[v] = acc[15:0];
        ni = si + IDX_MOVE[nib[2:0]];
        if (ni < 0) ni = 0;
        if (ni > IDX_TOP) ni = IDX_TOP;
        voice_idx[v] = ni[6:0];
        voice_tog[v] = ~voice_tog[v];
        adv = ~voice_tog[v];
      end
      CMD_START, CMD_LOOP: begin
        if (req.cmd == CMD_START || req.reload_word[31]) begin
          voice_pred[v] = req.reload_word[15:0];
          voice_idx[v] = (new_idx > IDX_TOP) ? 7'(IDX_TOP) : new_idx[6:0];
          voice_tog[v] = 1'b0;
        end
      end
      default: ;
    endcase
    res.sample = voice_pred[v];
    res.voice_out = req.voice;
    res.advance_byte = adv;
    res.step_index = voice_idx[v];
    return res;
  endfunction

  // Record accepted requests, then check accepted results against the oldest expectation
  always @(posedge clk) begin
    adpcm_out_t pred;
    adpcm_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        voice_pred[i] = '0;
        voice_idx[i] = '0;
        voice_tog[i] = 1'b0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        pred = decode_voice_step(in_data);
        pending_results = {pending_results, (row_known ? row_want : pred)};
        if (in_data.cmd == CMD_DECODE) decode_count++;
        else if (in_data.cmd != CMD_UNUSED) reload_count++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: sample=%0d voice=%0d adv=%0b idx=%0d",
                     out_data.sample, out_data.voice_out, out_data.advance_byte,
                     out_data.step_index);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (out_data.sample !== want.sample || out_data.voice_out !== want.voice_out ||
              out_data.advance_byte !== want.advance_byte ||
              out_data.step_index !== want.step_index) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"mismatch: exp sample=%0d voice=%0d adv=%0b idx=%0d,",
                        " got sample=%0d voice=%0d adv=%0b idx=%0d"},
                       want.sample, want.voice_out, want.advance_byte, want.step_index,
                       out_data.sample, out_data.voice_out, out_data.advance_byte,
                       out_data.step_index);
          end
        end
      end
    end
  end

  // Stall the result side at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one request after random idle cycles and hold it until accepted
  task automatic issue_request(input adpcm_in_t req, input logic known,
                               input adpcm_out_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    row_known <= known;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back or the drain limit runs out
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) hung = 1'b1;
  endtask

  // Mostly decodes with small magnitudes so the step index keeps moving
  function automatic adpcm_in_t random_request();
    adpcm_in_t req;
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) req.cmd = CMD_DECODE;
    else if (pick < 84) req.cmd = CMD_START;
    else if (pick < 95) req.cmd = CMD_LOOP;
    else req.cmd = CMD_UNUSED;
    req.voice = 4'($urandom_range(NUM_VOICES - 1));
    req.data_byte = 8'($urandom);
    if ($urandom_range(99) < 55) req.data_byte &= 8'hBB;
    req.reload_word = $urandom;
    if ($urandom_range(3) != 0) req.reload_word[23:16] = 8'($urandom_range(IDX_TOP));
    return req;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (SCRIPT[i]) issue_request(SCRIPT[i].req, SCRIPT[i].known, SCRIPT[i].want);
    drain_results();

    // Random requests under each handshake pattern, draining between phases
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = PHASE_IDLE[p];
      stall_pct = PHASE_STALL[p];
      for (int n = 0; n < RANDOM_REQUESTS / PHASES; n++)
        issue_request(random_request(), 1'b0, '0);
      drain_results();
    end
    stall_pct = 0;
    repeat (8) @(posedge clk);

    if (hung) begin
      $display("timed out with %0d results outstanding", pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      $display("covered %0d decodes and %0d reloads over %0d voices, %0d results checked",
               decode_count, reload_count, NUM_VOICES, checked_count);
      $display("handshake phases: free-running, sender idle, receiver stall, both");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("%0d mismatches, %0d results missing", mismatch_count,
                 pending_results.size());
        $display("status: fail");
      end
      $finish;
    end
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("run exceeded its time limit");
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/adpcm_vd_pkg.sv
rtl/core/multichannel_adpcm_voice_decoder.sv
tb/multichannel_adpcm_voice_decoder_tb.sv
